// File: design/grs_pkg.sv
// shared types, codes and reset values of the galvo raster scan generator
package grs_pkg;

  // default mirror converter resolution
  localparam int unsigned DAC_BITS_DEF = 8;

  // input word command codes
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_PATTERN = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam int unsigned REG_IDX_BITS = 3;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
  localparam reg_idx_t REG_X_START      = 3'd0;
  localparam reg_idx_t REG_X_END        = 3'd1;
  localparam reg_idx_t REG_X_STEP       = 3'd2;
  localparam reg_idx_t REG_Y_START      = 3'd3;
  localparam reg_idx_t REG_Y_END        = 3'd4;
  localparam reg_idx_t REG_Y_STEP       = 3'd5;
  localparam reg_idx_t REG_PHASE_WINDOW = 3'd6;
  localparam reg_idx_t REG_FRAME_COUNT  = 3'd7;

  // configuration reset values
  localparam logic [7:0]  RST_X_START      = 8'd0;
  localparam logic [7:0]  RST_X_END        = 8'd255;
  localparam logic [7:0]  RST_X_STEP       = 8'd5;
  localparam logic [7:0]  RST_Y_START      = 8'd0;
  localparam logic [7:0]  RST_Y_END        = 8'd255;
  localparam logic [7:0]  RST_Y_STEP       = 8'd5;
  localparam logic [31:0] RST_PHASE_WINDOW = 32'd327685;
  localparam logic [15:0] RST_FRAME_COUNT  = 16'd1;

  // pattern index divisor
  localparam logic [7:0] PATTERN_DIV = 8'd255;

endpackage

// File: design/galvo_raster_scan_generator_top.sv
// galvo raster scan generator: point sequencer with registered result word
//
//  channel  | ports                                              | direction
//  ---------+----------------------------------------------------+----------
//  input    | in_valid in_ready in_cmd in_continuous             | in
//           | in_pattern_index                                   |
//  result   | out_valid out_ready out_x_pos out_y_pos            | out
//           | out_point_valid out_last_point out_scanning        |
//  config   | cfg_we cfg_index cfg_wdata                         | in
//
// one input word per cycle unless stalled; its result word appears in the cycle
// after it is taken; a single result register follows the counter/step logic.
// a new word is taken whenever the result register is empty or being drained.
// rst_n is synchronous, active low; all registers but the payload take defaults.
// a stalled result holds its word and blocks further input until taken.
module galvo_raster_scan_generator_top #(
  parameter int unsigned DAC_BITS = grs_pkg::DAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic                        in_continuous,
  input  logic [15:0]                 in_pattern_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [DAC_BITS-1:0]         out_x_pos,
  output logic [DAC_BITS-1:0]         out_y_pos,
  output logic                        out_point_valid,
  output logic                        out_last_point,
  output logic                        out_scanning,
  input  logic                        cfg_we,
  input  logic [grs_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]                 cfg_wdata
);
  import grs_pkg::*;

  localparam int unsigned XW = DAC_BITS + 1;
  localparam int unsigned YW = DAC_BITS + 3;

  // configuration registers
  logic [7:0]  x_start_r, x_end_r, x_step_r, y_start_r, y_end_r, y_step_r;
  logic [31:0] phase_window_r;
  logic [15:0] frame_count_r;

  // scan state
  logic        scan_running_r, scan_running_nxt;
  logic        repeat_mode_r, repeat_mode_nxt;
  logic [15:0] frames_left_r, frames_left_nxt;
  logic [7:0]  x_phase_r, x_phase_nxt;
  logic [7:0]  y_phase_r, y_phase_nxt;
  logic [7:0]  column_r, column_nxt;
  logic [7:0]  row_r, row_nxt;
  logic        parity_r, parity_nxt;

  // result register
  logic                out_valid_r;
  logic [DAC_BITS-1:0] x_pos_r, x_pos_nxt;
  logic [DAC_BITS-1:0] y_pos_r, y_pos_nxt;
  logic                point_valid_r, point_valid_nxt;
  logic                last_point_r, last_point_nxt;

  logic       accept;
  cmd_t       cmd;
  logic [7:0] pw_x_min, pw_x_max, pw_y_min, pw_y_max;
  logic signed [9:0] x_lim, y_lim;
  logic [8:0] col_sum, row_sum;
  logic       col_less, row_less, raster_empty;
  logic [8:0] yv;
  logic [XW-1:0] x_sum_w;
  logic [YW-1:0] y_rise_w;
  logic signed [YW-1:0] y_fall_w;

  // pattern divide by 255
  logic [16:0] q_est_sum, q_prod, rem_est;
  logic [8:0]  q_est, q_fix;
  logic        rem_over;
  logic [7:0]  rem_fix;
  logic [YW-1:0] q_w, rem_w;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(in_cmd);

  assign pw_x_min = phase_window_r[7:0];
  assign pw_x_max = phase_window_r[15:8];
  assign pw_y_min = phase_window_r[23:16];
  assign pw_y_max = phase_window_r[31:24];

  // limits and counter steps
  assign x_lim    = $signed({2'b00, x_end_r}) - $signed({2'b00, x_step_r});
  assign y_lim    = $signed({2'b00, y_end_r}) - $signed({2'b00, y_step_r});
  assign col_sum  = {1'b0, column_r} + {1'b0, x_step_r};
  assign row_sum  = {1'b0, row_r} + {1'b0, y_step_r};
  assign col_less = $signed({1'b0, col_sum}) < x_lim;
  assign row_less = $signed({1'b0, row_sum}) < y_lim;

  assign raster_empty = (pw_x_min > pw_x_max) || (pw_y_min > pw_y_max) ||
                        ($signed({2'b00, x_start_r}) >= x_lim) ||
                        ($signed({2'b00, y_start_r}) >= y_lim);

  // point coordinates
  assign yv       = {1'b0, row_r} + {1'b0, y_phase_r};
  assign x_sum_w  = {{(XW-8){1'b0}}, column_r} + {{(XW-8){1'b0}}, x_phase_r};
  assign y_rise_w = {{(YW-9){1'b0}}, yv};
  assign y_fall_w = $signed({{(YW-10){y_lim[9]}}, y_lim}) -
                    $signed({{(YW-9){1'b0}}, yv});

  // quotient estimate never overshoots and is at most one short
  assign q_est_sum = {1'b0, in_pattern_index} + {9'd0, in_pattern_index[15:8]} + 17'd1;
  assign q_est     = q_est_sum[16:8];
  assign q_prod    = {q_est, 8'd0} - {8'd0, q_est};
  assign rem_est   = {1'b0, in_pattern_index} - q_prod;
  assign rem_over  = rem_est >= {9'd0, PATTERN_DIV};
  assign q_fix     = q_est + {8'd0, rem_over};
  assign rem_fix   = rem_over ? 8'(rem_est - {9'd0, PATTERN_DIV}) : rem_est[7:0];
  assign q_w       = {{(YW-9){1'b0}}, q_fix};
  assign rem_w     = {{(YW-8){1'b0}}, rem_fix};

  // next scan state and result word
  always_comb begin
    scan_running_nxt = scan_running_r;
    repeat_mode_nxt  = repeat_mode_r;
    frames_left_nxt  = frames_left_r;
    x_phase_nxt      = x_phase_r;
    y_phase_nxt      = y_phase_r;
    column_nxt       = column_r;
    row_nxt          = row_r;
    parity_nxt       = parity_r;
    x_pos_nxt        = '0;
    y_pos_nxt        = '0;
    point_valid_nxt  = 1'b0;
    last_point_nxt   = 1'b0;
    unique case (cmd)
      CMD_START: begin
        repeat_mode_nxt  = in_continuous;
        frames_left_nxt  = in_continuous ? 16'd0 : frame_count_r;
        x_phase_nxt      = pw_x_min;
        y_phase_nxt      = pw_y_min;
        column_nxt       = x_start_r;
        row_nxt          = y_start_r;
        parity_nxt       = 1'b0;
        scan_running_nxt = !raster_empty;
      end
      CMD_ADVANCE: begin
        if (scan_running_r) begin
          x_pos_nxt       = x_sum_w[DAC_BITS-1:0];
          y_pos_nxt       = parity_r ? y_fall_w[DAC_BITS-1:0]
                                     : y_rise_w[DAC_BITS-1:0];
          point_valid_nxt = 1'b1;
          parity_nxt      = !parity_r;
          // nested counters, innermost first
          if (row_less) begin
            row_nxt = row_sum[7:0];
          end else begin
            row_nxt = y_start_r;
            if (col_less) begin
              column_nxt = col_sum[7:0];
            end else begin
              column_nxt = x_start_r;
              if (y_phase_r < pw_y_max) begin
                y_phase_nxt = y_phase_r + 8'd1;
              end else begin
                y_phase_nxt = pw_y_min;
                if (x_phase_r < pw_x_max) begin
                  x_phase_nxt = x_phase_r + 8'd1;
                end else begin
                  x_phase_nxt = pw_x_min;
                  priority if (frames_left_r != 16'd0) begin
                    frames_left_nxt = frames_left_r - 16'd1;
                  end else if (repeat_mode_r) begin
                    column_nxt = x_start_r;
                    row_nxt    = y_start_r;
                    parity_nxt = 1'b0;
                  end else begin
                    scan_running_nxt = 1'b0;
                    last_point_nxt   = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      CMD_STOP: begin
        scan_running_nxt = 1'b0;
      end
      CMD_PATTERN: begin
        x_pos_nxt       = q_w[DAC_BITS-1:0];
        y_pos_nxt       = rem_w[DAC_BITS-1:0];
        point_valid_nxt = 1'b1;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r      <= RST_X_START;
      x_end_r        <= RST_X_END;
      x_step_r       <= RST_X_STEP;
      y_start_r      <= RST_Y_START;
      y_end_r        <= RST_Y_END;
      y_step_r       <= RST_Y_STEP;
      phase_window_r <= RST_PHASE_WINDOW;
      frame_count_r  <= RST_FRAME_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_START:      x_start_r      <= cfg_wdata[7:0];
        REG_X_END:        x_end_r        <= cfg_wdata[7:0];
        REG_X_STEP:       x_step_r       <= cfg_wdata[7:0];
        REG_Y_START:      y_start_r      <= cfg_wdata[7:0];
        REG_Y_END:        y_end_r        <= cfg_wdata[7:0];
        REG_Y_STEP:       y_step_r       <= cfg_wdata[7:0];
        REG_PHASE_WINDOW: phase_window_r <= cfg_wdata;
        REG_FRAME_COUNT:  frame_count_r  <= cfg_wdata[15:0];
      endcase
    end
  end

  // scan state update on each taken word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_running_r <= 1'b0;
      repeat_mode_r  <= 1'b0;
      frames_left_r  <= '0;
      x_phase_r      <= '0;
      y_phase_r      <= '0;
      column_r       <= '0;
      row_r          <= '0;
      parity_r       <= 1'b0;
    end else if (accept) begin
      scan_running_r <= scan_running_nxt;
      repeat_mode_r  <= repeat_mode_nxt;
      frames_left_r  <= frames_left_nxt;
      x_phase_r      <= x_phase_nxt;
      y_phase_r      <= y_phase_nxt;
      column_r       <= column_nxt;
      row_r          <= row_nxt;
      parity_r       <= parity_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= accept;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      x_pos_r       <= x_pos_nxt;
      y_pos_r       <= y_pos_nxt;
      point_valid_r <= point_valid_nxt;
      last_point_r  <= last_point_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_pos       = x_pos_r;
  assign out_y_pos       = y_pos_r;
  assign out_point_valid = point_valid_r;
  assign out_last_point  = last_point_r;
  assign out_scanning    = scan_running_r;

endmodule

// File: design/grs_checker.sv
// port-level checks of the galvo raster scan generator and their bind
module grs_checker #(
  parameter int unsigned DAC_BITS = grs_pkg::DAC_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_cmd,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DAC_BITS-1:0] out_x_pos,
  input logic [DAC_BITS-1:0] out_y_pos,
  input logic                out_point_valid,
  input logic                out_last_point,
  input logic                out_scanning
);
  import grs_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_pos) && $stable(out_y_pos)
      && $stable(out_point_valid) && $stable(out_last_point))
    else $error("stalled result word changed");

  // an empty result register always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // no coordinates without a point
  a_zero_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_x_pos == '0 && out_y_pos == '0 && !out_last_point)
    else $error("coordinates or last flag without a point");

  // the last point ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_point |-> out_point_valid && !out_scanning)
    else $error("last point with run still active");

  // a taken stop gives an idle, pointless result next cycle
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_STOP |=> out_valid && !out_scanning
      && !out_point_valid)
    else $error("stop not reflected in result word");

endmodule

bind galvo_raster_scan_generator_top grs_checker #(.DAC_BITS(DAC_BITS)) u_grs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_x_pos       (out_x_pos),
  .out_y_pos       (out_y_pos),
  .out_point_valid (out_point_valid),
  .out_last_point  (out_last_point),
  .out_scanning    (out_scanning)
);

// File: tb/galvo_raster_scan_generator_top_test.sv
// self-checking testbench of the galvo raster scan generator top level
module galvo_raster_scan_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import grs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 950;
  localparam int PRESSURE_AFTER = 400;
  localparam int PRESSURE_HOLD  = 300;
  localparam int PATTERN_MAX    = 65279;

  typedef struct packed {
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic       point_valid;
    logic       last_point;
    logic       scanning;
  } scan_point_t;

  // predicts the point word of every accepted input word and checks results
  class scan_scoreboard;
    logic [7:0]  x_start, x_end, x_step, y_start, y_end, y_step;
    logic [31:0] phase_window;
    logic [15:0] frame_count;
    bit          running, repeat_mode, parity;
    logic [15:0] frames_left;
    logic [7:0]  x_phase, y_phase;
    logic [8:0]  column, row;
    scan_point_t expected_points[$];
    int          errors;

    function new();
      x_start = RST_X_START;
      x_end = RST_X_END;
      x_step = RST_X_STEP;
      y_start = RST_Y_START;
      y_end = RST_Y_END;
      y_step = RST_Y_STEP;
      phase_window = RST_PHASE_WINDOW;
      frame_count = RST_FRAME_COUNT;
      running = 0;
      repeat_mode = 0;
      parity = 0;
      frames_left = '0;
      x_phase = '0;
      y_phase = '0;
      column = '0;
      row = '0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_X_START:      x_start = data[7:0];
        REG_X_END:        x_end = data[7:0];
        REG_X_STEP:       x_step = data[7:0];
        REG_Y_START:      y_start = data[7:0];
        REG_Y_END:        y_end = data[7:0];
        REG_Y_STEP:       y_step = data[7:0];
        REG_PHASE_WINDOW: phase_window = data;
        REG_FRAME_COUNT:  frame_count = data[15:0];
        default: ;
      endcase
    endfunction

    // signed column and row limits
    function int x_lim();
      int v;
      v = x_end;
      v = v - int'(x_step);
      return v;
    endfunction

    function int y_lim();
      int v;
      v = y_end;
      v = v - int'(y_step);
      return v;
    endfunction

    function bit raster_empty();
      int xs, ys;
      xs = x_start;
      ys = y_start;
      return (phase_window[7:0] > phase_window[15:8]) ||
             (phase_window[23:16] > phase_window[31:24]) ||
             (xs >= x_lim()) || (ys >= y_lim());
    endfunction

    function void frame_begin();
      x_phase = phase_window[7:0];
      y_phase = phase_window[23:16];
      column = {1'b0, x_start};
      row = {1'b0, y_start};
      parity = 0;
    endfunction

    // row innermost, then column, y phase, x phase, frames; 1 when the run ends
    function bit step_counters();
      int r, c;
      r = row;
      r = r + int'(y_step);
      if (r < y_lim()) begin
        row = r[8:0];
        return 0;
      end
      row = {1'b0, y_start};
      c = column;
      c = c + int'(x_step);
      if (c < x_lim()) begin
        column = c[8:0];
        return 0;
      end
      column = {1'b0, x_start};
      if (y_phase < phase_window[31:24]) begin
        y_phase++;
        return 0;
      end
      y_phase = phase_window[23:16];
      if (x_phase < phase_window[15:8]) begin
        x_phase++;
        return 0;
      end
      x_phase = phase_window[7:0];
      if (frames_left > 0) begin
        frames_left--;
        return 0;
      end
      if (repeat_mode) begin
        frame_begin();
        return 0;
      end
      return 1;
    endfunction

    function void note_word(cmd_t cmd, bit cont, logic [15:0] idx);
      scan_point_t p;
      int yv, yl, cv;
      p = '0;
      case (cmd)
        CMD_START: begin
          repeat_mode = cont;
          frames_left = cont ? 16'd0 : frame_count;
          frame_begin();
          running = !raster_empty();
        end
        CMD_ADVANCE: begin
          if (running) begin
            yv = row;
            yv = yv + int'(y_phase);
            cv = column;
            cv = cv + int'(x_phase);
            p.x_pos = cv[7:0];
            if (!parity) begin
              p.y_pos = yv[7:0];
            end else begin
              yl = y_lim() - yv;
              p.y_pos = yl[7:0];
            end
            parity ^= 1'b1;
            p.point_valid = 1'b1;
            if (step_counters()) begin
              running = 0;
              p.last_point = 1'b1;
            end
          end
        end
        CMD_STOP: running = 0;
        default: begin
          p.x_pos = 8'(idx / PATTERN_DIV);
          p.y_pos = 8'(idx % PATTERN_DIV);
          p.point_valid = 1'b1;
        end
      endcase
      p.scanning = running;
      expected_points.push_back(p);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(scan_point_t got);
      scan_point_t want;
      if (expected_points.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      want = expected_points.pop_front();
      compare_field("x_pos", want.x_pos, got.x_pos);
      compare_field("y_pos", want.y_pos, got.y_pos);
      compare_field("point_valid", 8'(want.point_valid), 8'(got.point_valid));
      compare_field("last_point", 8'(want.last_point), 8'(got.last_point));
      compare_field("scanning", 8'(want.scanning), 8'(got.scanning));
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic        in_continuous;
  logic [15:0] in_pattern_index;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_x_pos;
  logic [7:0]  out_y_pos;
  logic        out_point_valid;
  logic        out_last_point;
  logic        out_scanning;
  logic        cfg_we;
  logic [REG_IDX_BITS-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  scan_scoreboard sb = new();
  int  items_sent = 0;
  int  results_seen = 0;
  bit  phase_busy = 0;
  bit  hold_done = 0;

  galvo_raster_scan_generator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_continuous    (in_continuous),
    .in_pattern_index (in_pattern_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x_pos        (out_x_pos),
    .out_y_pos        (out_y_pos),
    .out_point_valid  (out_point_valid),
    .out_last_point   (out_last_point),
    .out_scanning     (out_scanning),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle lengths: mostly short, a few long, none at all in quiet stretches
  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one word and wait for its handshake
  task automatic send_word(cmd_t cmd, bit cont, logic [15:0] idx, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_continuous = cont;
    in_pattern_index = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(cmd, cont, idx);
    items_sent++;
  endtask

  task automatic send_random_word(cmd_t cmd, int gap);
    send_word(cmd, 1'($urandom_range(0, 1)), 16'($urandom_range(0, PATTERN_MAX)), gap);
  endtask

  // drop valid and wait until every result word has drained
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(int xst, int xe, int xs, int yst, int ye, int ys,
                              logic [31:0] pw, int fc);
    write_reg(REG_X_START, 32'(xst));
    write_reg(REG_X_END, 32'(xe));
    write_reg(REG_X_STEP, 32'(xs));
    write_reg(REG_Y_START, 32'(yst));
    write_reg(REG_Y_END, 32'(ye));
    write_reg(REG_Y_STEP, 32'(ys));
    write_reg(REG_PHASE_WINDOW, pw);
    write_reg(REG_FRAME_COUNT, 32'(fc));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one of the two field extremes, or a random value in between
  function automatic int pick_extreme(int lo, int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return lo;
    if (r < 80) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [7:0] pick_phase_max(int pmin);
    int pmax;
    if (pmin > 0 && $urandom_range(0, 9) == 0) return 8'(pmin - 1);
    pmax = pmin + $urandom_range(0, 1);
    if (pmax > 255) pmax = 255;
    return 8'(pmax);
  endfunction

  // new register setting: tiny rasters mostly, extremes and raw random too
  task automatic configure_random();
    int kind, xst, xe, xs, yst, ye, ys, fc, pxmin, pymin;
    logic [31:0] pw;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      xs = $urandom_range(1, 8);
      xst = $urandom_range(0, 230);
      xe = xst + xs * ($urandom_range(1, 2) + 1);
      if (xe > 255) xe = 255;
      ys = $urandom_range(1, 8);
      yst = $urandom_range(0, 230);
      ye = yst + ys * ($urandom_range(1, 3) + 1);
      if (ye > 255) ye = 255;
      pxmin = $urandom_range(0, 255);
      pymin = $urandom_range(0, 255);
      pw = {pick_phase_max(pymin), 8'(pymin), pick_phase_max(pxmin), 8'(pxmin)};
      fc = $urandom_range(0, 2);
    end else if (kind < 8) begin
      xst = pick_extreme(0, 255);
      xe = pick_extreme(0, 255);
      xs = pick_extreme(1, 255);
      yst = pick_extreme(0, 255);
      ye = pick_extreme(0, 255);
      ys = pick_extreme(1, 255);
      case ($urandom_range(0, 2))
        0: pw = 32'h0000_0000;
        1: pw = 32'hFFFF_FFFF;
        default: pw = $urandom;
      endcase
      fc = pick_extreme(0, 65535);
    end else begin
      xst = $urandom_range(0, 255);
      xe = $urandom_range(0, 255);
      xs = $urandom_range(1, 255);
      yst = $urandom_range(0, 255);
      ye = $urandom_range(0, 255);
      ys = $urandom_range(1, 255);
      pw = $urandom;
      fc = $urandom_range(0, 65535);
    end
    apply_config(xst, xe, xs, yst, ye, ys, pw, fc);
  endtask

  // mostly start followed by a run of advances, with stray words mixed in
  task automatic run_phase(int n_items);
    int sent, n_adv, r;
    bit no_idle;
    phase_busy = 1;
    no_idle = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        send_random_word(CMD_START, pick_gap(no_idle));
        sent++;
        n_adv = $urandom_range(1, 60);
        repeat (n_adv) begin
          r = $urandom_range(0, 99);
          if (r < 88) send_random_word(CMD_ADVANCE, pick_gap(no_idle));
          else if (r < 94) send_random_word(CMD_PATTERN, pick_gap(no_idle));
          else if (r < 97) send_random_word(CMD_STOP, pick_gap(no_idle));
          else send_random_word(CMD_START, pick_gap(no_idle));
          sent++;
        end
      end else begin
        send_random_word(cmd_t'($urandom_range(0, 3)), pick_gap(no_idle));
        sent++;
      end
    end
    phase_busy = 0;
  endtask

  // directed words: idle behavior, patterns, empty raster, wraps and restarts
  task automatic run_directed();
    send_word(CMD_ADVANCE, 1'b0, 16'd0, 0);
    send_word(CMD_STOP, 1'b1, 16'hFFFF, 0);
    send_word(CMD_PATTERN, 1'b0, 16'd0, 0);
    send_word(CMD_PATTERN, 1'b1, 16'(PATTERN_MAX), 0);
    send_word(CMD_PATTERN, 1'b0, 16'd254, 0);
    // reset phase window has x min above x max, so starts stay idle
    send_word(CMD_START, 1'b0, 16'd0, 0);
    send_word(CMD_START, 1'b1, 16'd0, 0);
    send_word(CMD_ADVANCE, 1'b0, 16'd0, 0);
    settle();
    // two columns, two rows, x and y wrap past 255, falling y goes negative
    apply_config(250, 255, 2, 252, 255, 1, {8'd11, 8'd10, 8'd200, 8'd200}, 0);
    send_word(CMD_START, 1'b0, 16'd0, 0);
    repeat (9) send_word(CMD_ADVANCE, 1'b0, 16'd0, 0);
    send_word(CMD_START, 1'b1, 16'd0, 0);
    repeat (2) send_word(CMD_ADVANCE, 1'b0, 16'd0, 0);
    send_word(CMD_START, 1'b0, 16'd0, 0);
    send_word(CMD_ADVANCE, 1'b0, 16'd0, 0);
    send_word(CMD_STOP, 1'b0, 16'd0, 0);
    send_word(CMD_ADVANCE, 1'b0, 16'd0, 0);
    settle();
  endtask

  // stimulus and end of run
  initial begin
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_START;
    in_continuous = 1'b0;
    in_pattern_index = '0;
    cfg_we = 1'b0;
    cfg_index = REG_X_START;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      configure_random();
      run_phase($urandom_range(30, 70));
      settle();
    end
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side: random back-pressure, one long hold-off while words keep coming
  initial begin
    int stall_left;
    bit no_idle;
    scan_point_t got;
    stall_left = 0;
    no_idle = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.x_pos = out_x_pos;
        got.y_pos = out_y_pos;
        got.point_valid = out_point_valid;
        got.last_point = out_last_point;
        got.scanning = out_scanning;
        sb.check_result(got);
        results_seen++;
        if (results_seen % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
        stall_left = pick_gap(no_idle);
        if (!hold_done && phase_busy && results_seen >= PRESSURE_AFTER) begin
          hold_done = 1;
          stall_left = PRESSURE_HOLD;
        end
      end
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
